@@ design/mcvrd_pkg.sv @@
// Package for the multi-channel virtual rate divider.
// Holds the command and response transaction types and the operation codes.
// No dependencies.
package mcvrd_pkg;

    // Operation codes carried in the command transaction.
    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_OPEN     = 3'd1;
    localparam logic [2:0] OP_CLOSE    = 3'd2;
    localparam logic [2:0] OP_ARM      = 3'd3;
    localparam logic [2:0] OP_SET_RATE = 3'd4;
    localparam logic [2:0] OP_POLL     = 3'd5;

    // Rate assigned when a channel is opened.
    localparam int unsigned OPEN_RATE = 2;

    // Length that a set-rate request must carry.
    localparam logic [7:0] RATE_LEN = 8'd4;

    // Command transaction.
    typedef struct packed {
        logic [2:0]         operation;
        logic [2:0]         channel;
        logic [7:0]         active_mask;
        logic signed [31:0] rate_value;
        logic [7:0]         byte_count;
    } t_cmd;

    // Response transaction.
    typedef struct packed {
        logic       status;
        logic       channel_fired;
        logic [7:0] fired_mask;
    } t_rsp;

endpackage

@@ design/multi_channel_virtual_rate_divider.sv @@
// Top level of the multi-channel virtual rate divider.
// Depends on mcvrd_pkg for the transaction types and operation codes.
// Holds the channel bank memories, the tick walker and the response register.

// A command is taken when start is high and busy is low. Open, close, arm,
// set rate, poll and the unused codes finish in the accepting cycle, busy
// stays low, and the response strobes on o_valid in the next cycle. A tick
// walks the channel bank one channel per cycle through the single read and
// write port of the count memory: with N = min(CHANNELS, 8) it holds busy while
// it walks the first N channels, and its response strobes on o_valid in the
// cycle that busy falls. Each response is flagged on o_valid for exactly one
// cycle; the receiver cannot stall it and must take it then.
module multi_channel_virtual_rate_divider #(
    parameter int CHANNELS  = 8,
    parameter int TICK_RATE = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  mcvrd_pkg::t_cmd   i_cmd,
    output logic              o_valid,
    output mcvrd_pkg::t_rsp   o_rsp
);

    // Widths derived from the parameters.
    localparam int CW     = $clog2(TICK_RATE + 1);
    localparam int IW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WALK_N = (CHANNELS < 8) ? CHANNELS : 8;

    localparam logic [CW-1:0] RELOAD = CW'(TICK_RATE);
    localparam logic [CW-1:0] OPEN_R = CW'(mcvrd_pkg::OPEN_RATE);

    // Sequencer states.
    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    // Control state.
    logic                r_state, n_state;
    logic [3:0]          r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [2:0]          r_pidx, n_pidx;
    logic [CHANNELS-1:0] r_open, n_open;
    logic [CHANNELS-1:0] r_fired, n_fired;
    logic [CHANNELS-1:0] r_cnt_set, n_cnt_set;
    logic [CHANNELS-1:0] r_rate_set, n_rate_set;
    logic                r_out_vld, n_out_vld;

    // Payload registers.
    logic [2:0]      r_ch;
    logic [7:0]      r_act;
    mcvrd_pkg::t_rsp r_out, n_out;

    // Channel bank memories and their registered read data.
    logic [CW-1:0] r_cnt_mem  [CHANNELS];
    logic [CW-1:0] r_rate_mem [CHANNELS];
    logic [CW-1:0] r_cnt_q;
    logic [CW-1:0] r_rate_q;
    logic          r_cnt_vq;
    logic          r_rate_vq;

    // Memory port controls.
    logic          cnt_we;
    logic [IW-1:0] cnt_waddr;
    logic [CW-1:0] cnt_wdata;
    logic          rate_we;
    logic [IW-1:0] rate_waddr;
    logic [CW-1:0] rate_wdata;
    logic [IW-1:0] rd_addr;

    // Decode helpers.
    logic          accept;
    logic [6:0]    cmd_ch_ext;
    logic          cmd_ch_ok;
    logic [IW-1:0] cmd_addr;
    logic [6:0]    idx_ext;
    logic [6:0]    pidx_ext;
    logic [IW-1:0] pidx_addr;
    logic [31:0]   rate_raw;
    logic [31:0]   rate_dec;
    logic          rate_ok;
    logic          issue;
    logic [CW-1:0] cnt_eff;
    logic [CW-1:0] rate_eff;
    logic [2:0]    rsp_ch;
    logic [7:0]    fired_view;
    logic          rsp_status;

    assign accept     = start && (r_state == S_IDLE);
    assign cmd_ch_ext = 7'(i_cmd.channel);
    assign cmd_ch_ok  = (32'(cmd_ch_ext) < 32'(CHANNELS));
    assign cmd_addr   = cmd_ch_ext[IW-1:0];
    assign idx_ext    = 7'(r_idx);
    assign pidx_ext   = 7'(r_pidx);
    assign pidx_addr  = pidx_ext[IW-1:0];
    assign rd_addr    = idx_ext[IW-1:0];
    assign issue      = (r_idx < 4'(WALK_N));

    // Set-rate check: length of four and a power of two from 2 to TICK_RATE.
    assign rate_raw = 32'(i_cmd.rate_value);
    assign rate_dec = rate_raw - 32'd1;
    assign rate_ok  = (i_cmd.byte_count == mcvrd_pkg::RATE_LEN) && !rate_raw[31] &&
                      (rate_raw >= 32'd2) && (rate_raw <= 32'(TICK_RATE)) &&
                      ((rate_raw & rate_dec) == 32'd0);

    // Entries never written read as their reset values.
    assign cnt_eff  = r_cnt_vq  ? r_cnt_q  : RELOAD;
    assign rate_eff = r_rate_vq ? r_rate_q : '0;

    // Fired flags of the first eight channels, zero where no channel exists.
    genvar g;
    generate
        for (g = 0; g < 8; g++) begin : g_view
            if (g < CHANNELS) begin : g_have
                assign fired_view[g] = n_fired[g];
            end else begin : g_none
                assign fired_view[g] = 1'b0;
            end
        end
    endgenerate

    assign rsp_ch = (r_state == S_IDLE) ? i_cmd.channel : r_ch;

    // Sequencer and per-channel command logic.
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_pend     = 1'b0;
        n_pidx     = r_idx[2:0];
        n_open     = r_open;
        n_fired    = r_fired;
        n_cnt_set  = r_cnt_set;
        n_rate_set = r_rate_set;
        n_out_vld  = 1'b0;
        rsp_status = 1'b0;
        cnt_we     = 1'b0;
        cnt_waddr  = cmd_addr;
        cnt_wdata  = RELOAD;
        rate_we    = 1'b0;
        rate_waddr = cmd_addr;
        rate_wdata = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd.operation)
                        mcvrd_pkg::OP_TICK: begin
                            n_state = S_WALK;
                            n_idx   = '0;
                        end
                        mcvrd_pkg::OP_OPEN: begin
                            if (cmd_ch_ok) begin
                                rate_we            = 1'b1;
                                rate_wdata         = OPEN_R;
                                cnt_we             = 1'b1;
                                n_fired[cmd_addr]  = 1'b0;
                                n_open[cmd_addr]   = 1'b1;
                            end
                        end
                        mcvrd_pkg::OP_CLOSE: begin
                            if (cmd_ch_ok) begin
                                rate_we            = 1'b1;
                                cnt_we             = 1'b1;
                                n_fired[cmd_addr]  = 1'b0;
                                n_open[cmd_addr]   = 1'b0;
                            end
                        end
                        mcvrd_pkg::OP_ARM: begin
                            if (cmd_ch_ok) begin
                                cnt_we            = 1'b1;
                                n_fired[cmd_addr] = 1'b0;
                            end
                        end
                        mcvrd_pkg::OP_SET_RATE: begin
                            if (cmd_ch_ok && rate_ok) begin
                                rate_we    = 1'b1;
                                rate_wdata = rate_raw[CW-1:0];
                            end else begin
                                rsp_status = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (rate_we) begin
                        n_rate_set[cmd_addr] = 1'b1;
                    end
                    if (cnt_we) begin
                        n_cnt_set[cmd_addr] = 1'b1;
                    end
                    // Non-tick commands answer in the next cycle.
                    if (i_cmd.operation != mcvrd_pkg::OP_TICK) begin
                        n_out_vld = 1'b1;
                    end
                end
            end
            S_WALK: begin
                // Issue the read of the next channel.
                if (issue) begin
                    n_pend = 1'b1;
                    n_idx  = r_idx + 4'd1;
                end
                // Update the channel whose count and rate were read last cycle.
                if (r_pend && r_act[r_pidx] && r_open[pidx_addr]) begin
                    cnt_we                = 1'b1;
                    cnt_waddr             = pidx_addr;
                    n_cnt_set[pidx_addr]  = 1'b1;
                    if (cnt_eff <= rate_eff) begin
                        n_fired[pidx_addr] = 1'b1;
                        cnt_wdata          = RELOAD;
                    end else begin
                        cnt_wdata = cnt_eff - rate_eff;
                    end
                end
                // Walk done: report the flags.
                if (!issue && !r_pend) begin
                    n_state   = S_IDLE;
                    n_out_vld = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Response built from the flags as they stand after this transaction.
    always_comb begin
        n_out = r_out;
        if (n_out_vld) begin
            n_out.status        = rsp_status;
            n_out.channel_fired = fired_view[rsp_ch];
            n_out.fired_mask    = fired_view;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_pend     <= 1'b0;
            r_pidx     <= '0;
            r_open     <= '0;
            r_fired    <= '0;
            r_cnt_set  <= '0;
            r_rate_set <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_pend     <= n_pend;
            r_pidx     <= n_pidx;
            r_open     <= n_open;
            r_fired    <= n_fired;
            r_cnt_set  <= n_cnt_set;
            r_rate_set <= n_rate_set;
            r_out_vld  <= n_out_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (accept) begin
            r_ch  <= i_cmd.channel;
            r_act <= i_cmd.active_mask;
        end
    end

    // Count memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_q  <= r_cnt_mem[rd_addr];
        r_cnt_vq <= r_cnt_set[rd_addr];
    end

    // Rate memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (rate_we) begin
            r_rate_mem[rate_waddr] <= rate_wdata;
        end
        r_rate_q  <= r_rate_mem[rd_addr];
        r_rate_vq <= r_rate_set[rd_addr];
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_out_vld;
    assign o_rsp   = r_out;

    // A per-channel command answers in the very next cycle.
    a_cmd_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.operation != mcvrd_pkg::OP_TICK)) |=> o_valid)
        else $error("per-channel command gave no response in the next cycle");

    // A tick answers once the walk of the bank is over.
    a_tick_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.operation == mcvrd_pkg::OP_TICK))
            |-> ##(WALK_N + 3) o_valid)
        else $error("tick response missing at the end of the walk");

    // No channel update is left pending once the sequencer is idle.
    a_no_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !r_pend)
        else $error("channel update pending while idle");

endmodule

@@ tb/mcvrd_checker.sv @@
// Checker for the multi-channel virtual rate divider testbench.
// Depends on mcvrd_pkg; predicts each response from the accepted commands and compares.
// Reports mismatches, response count pending and leftovers to the testbench top.
module mcvrd_checker #(
    parameter int TICK_RATE = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_busy,
    input  mcvrd_pkg::t_cmd i_cmd,
    input  logic            i_valid,
    input  mcvrd_pkg::t_rsp i_rsp,
    input  logic            i_check_end,
    output int              o_mismatches,
    output int              o_pending
);

    localparam int NUM_CH = 8;
    localparam logic [10:0] RELOAD = 11'(TICK_RATE);

    // Shadow copy of the channel bank.
    logic [10:0] down_count[NUM_CH];
    logic [10:0] ch_rate[NUM_CH];
    bit          ch_open[NUM_CH];
    bit          ch_fired[NUM_CH];

    mcvrd_pkg::t_rsp expected_rsp_q[$];
    int              mismatch_count = 0;
    bit              end_checked = 1'b0;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("ERROR at %0t: %s", $time, what);
    endtask

    task automatic clear_bank();
        for (int c = 0; c < NUM_CH; c++) begin
            down_count[c] = RELOAD;
            ch_rate[c]    = '0;
            ch_open[c]    = 1'b0;
            ch_fired[c]   = 1'b0;
        end
    endtask

    // A rate is legal only with a length of four and as a power of two in range.
    function automatic bit rate_legal(input logic signed [31:0] r, input logic [7:0] len);
        if (len != mcvrd_pkg::RATE_LEN) return 1'b0;
        if (r < 2 || r > TICK_RATE) return 1'b0;
        return (r & (r - 1)) == 0;
    endfunction

    // Applies one command to the shadow bank and builds the response it causes.
    task automatic advance_bank(input mcvrd_pkg::t_cmd c, output mcvrd_pkg::t_rsp r);
        int ch;
        ch = int'(c.channel);
        r  = '0;
        case (c.operation)
            mcvrd_pkg::OP_TICK: begin
                for (int k = 0; k < NUM_CH; k++) begin
                    if (c.active_mask[k] && ch_open[k]) begin
                        // Reaching zero or below fires, even after a rate change mid-count.
                        if (down_count[k] <= ch_rate[k]) begin
                            ch_fired[k]   = 1'b1;
                            down_count[k] = RELOAD;
                        end else begin
                            down_count[k] = down_count[k] - ch_rate[k];
                        end
                    end
                end
            end
            mcvrd_pkg::OP_OPEN: begin
                ch_rate[ch]    = 11'(mcvrd_pkg::OPEN_RATE);
                down_count[ch] = RELOAD;
                ch_fired[ch]   = 1'b0;
                ch_open[ch]    = 1'b1;
            end
            mcvrd_pkg::OP_CLOSE: begin
                ch_rate[ch]    = '0;
                down_count[ch] = RELOAD;
                ch_fired[ch]   = 1'b0;
                ch_open[ch]    = 1'b0;
            end
            mcvrd_pkg::OP_ARM: begin
                ch_fired[ch]   = 1'b0;
                down_count[ch] = RELOAD;
            end
            mcvrd_pkg::OP_SET_RATE: begin
                if (rate_legal(c.rate_value, c.byte_count)) begin
                    ch_rate[ch] = c.rate_value[10:0];
                end else begin
                    r.status = 1'b1;
                end
            end
            default: begin
                // Poll and the unused codes change nothing.
            end
        endcase
        r.channel_fired = ch_fired[ch];
        for (int k = 0; k < NUM_CH; k++) begin
            r.fired_mask[k] = ch_fired[k];
        end
    endtask

    // Compare each response with the oldest prediction, then record new commands.
    always @(posedge i_clk) begin : watch
        mcvrd_pkg::t_rsp want;
        if (!i_rst_n) begin
            clear_bank();
            expected_rsp_q.delete();
        end else begin
            if (i_valid) begin
                if (expected_rsp_q.size() == 0) begin
                    report_mismatch($sformatf("response %h with no command pending", i_rsp));
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (i_rsp.status !== want.status) begin
                        report_mismatch($sformatf("status got %b want %b",
                                                  i_rsp.status, want.status));
                    end
                    if (i_rsp.channel_fired !== want.channel_fired) begin
                        report_mismatch($sformatf("channel_fired got %b want %b",
                                                  i_rsp.channel_fired, want.channel_fired));
                    end
                    if (i_rsp.fired_mask !== want.fired_mask) begin
                        report_mismatch($sformatf("fired_mask got %h want %h",
                                                  i_rsp.fired_mask, want.fired_mask));
                    end
                end
            end
            if (i_start && !i_busy) begin
                advance_bank(i_cmd, want);
                expected_rsp_q.push_back(want);
            end
            if (i_check_end && !end_checked) begin
                end_checked = 1'b1;
                if (expected_rsp_q.size() != 0) begin
                    report_mismatch($sformatf("%0d responses never arrived",
                                              expected_rsp_q.size()));
                end
            end
        end
        o_pending    <= expected_rsp_q.size();
        o_mismatches <= mismatch_count;
    end

endmodule

@@ tb/tb_multi_channel_virtual_rate_divider.sv @@
// Testbench top for the multi-channel virtual rate divider.
// Depends on mcvrd_pkg, the block itself and mcvrd_checker; drives commands and gives the verdict.
// Directed commands come first, then random ones with random gaps between transactions.
module tb_multi_channel_virtual_rate_divider;

    // Operation codes that the block does not use.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS = 1300;

    logic            i_clk     = 1'b0;
    logic            i_rst_n   = 1'b0;
    logic            start     = 1'b0;
    logic            busy;
    mcvrd_pkg::t_cmd cmd       = '0;
    logic            rsp_valid;
    mcvrd_pkg::t_rsp rsp;
    logic            check_end = 1'b0;
    int              mismatches;
    int              pending;
    bit              calm;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    multi_channel_virtual_rate_divider dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (cmd),
        .o_valid (rsp_valid),
        .o_rsp   (rsp)
    );

    mcvrd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (cmd),
        .i_valid      (rsp_valid),
        .i_rsp        (rsp),
        .i_check_end  (check_end),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    function automatic mcvrd_pkg::t_cmd make_cmd(input logic [2:0] op, input logic [2:0] ch,
                                                 input logic [7:0] mask,
                                                 input logic signed [31:0] rate,
                                                 input logic [7:0] len);
        mcvrd_pkg::t_cmd c;
        c.operation   = op;
        c.channel     = ch;
        c.active_mask = mask;
        c.rate_value  = rate;
        c.byte_count  = len;
        return c;
    endfunction

    // Mostly well-formed commands with random content, plus some noise.
    function automatic mcvrd_pkg::t_cmd random_cmd();
        mcvrd_pkg::t_cmd c;
        int              sel;
        c.operation   = mcvrd_pkg::OP_POLL;
        c.channel     = 3'($urandom);
        c.active_mask = 8'($urandom);
        c.rate_value  = $urandom;
        c.byte_count  = 8'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            c.operation = mcvrd_pkg::OP_TICK;
            if ($urandom_range(0, 9) < 8) c.active_mask = 8'hFF;
        end else if (sel < 50) begin
            c.operation = mcvrd_pkg::OP_OPEN;
        end else if (sel < 55) begin
            c.operation = mcvrd_pkg::OP_CLOSE;
        end else if (sel < 62) begin
            c.operation = mcvrd_pkg::OP_ARM;
        end else if (sel < 82) begin
            c.operation = mcvrd_pkg::OP_SET_RATE;
            if ($urandom_range(0, 3) != 0) begin
                c.rate_value = 32'sd1 <<< $urandom_range(1, 10);
                c.byte_count = mcvrd_pkg::RATE_LEN;
            end else if ($urandom_range(0, 1) != 0) begin
                c.byte_count = mcvrd_pkg::RATE_LEN;
            end
        end else if (sel < 95) begin
            c.operation = mcvrd_pkg::OP_POLL;
        end else begin
            c.operation = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
        end
        return c;
    endfunction

    // Gap length between transactions: mostly none, some short, a few long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Holds a command on the bus until the block takes it.
    task automatic issue_cmd(input mcvrd_pkg::t_cmd c);
        cmd   <= c;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic pause(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stops sending until every predicted response has come back.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Directed commands, then random traffic.
    initial begin
        mcvrd_pkg::t_cmd directed[$];
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed.push_back(make_cmd(mcvrd_pkg::OP_TICK, 3'd0, 8'hFF, 32'sd0, 8'd0));
        directed.push_back(make_cmd(mcvrd_pkg::OP_POLL, 3'd7, 8'h00, 32'sd0, 8'd0));
        directed.push_back(make_cmd(mcvrd_pkg::OP_OPEN, 3'd0, 8'h00, 32'sd0, 8'd0));
        directed.push_back(make_cmd(mcvrd_pkg::OP_OPEN, 3'd7, 8'h00, 32'sd0, 8'd0));
        directed.push_back(make_cmd(mcvrd_pkg::OP_SET_RATE, 3'd0, 8'h00, 32'sd1024,
                                    mcvrd_pkg::RATE_LEN));
        // Top rate on channel zero fires on the first tick.
        directed.push_back(make_cmd(mcvrd_pkg::OP_TICK, 3'd0, 8'h01, 32'sd0, 8'd0));
        directed.push_back(make_cmd(mcvrd_pkg::OP_POLL, 3'd0, 8'h00, 32'sd0, 8'd0));
        // Rejected rates: out of range, negative, not a power of two, wrong length.
        directed.push_back(make_cmd(mcvrd_pkg::OP_SET_RATE, 3'd7, 8'h00, 32'sh7FFFFFFF,
                                    mcvrd_pkg::RATE_LEN));
        directed.push_back(make_cmd(mcvrd_pkg::OP_SET_RATE, 3'd7, 8'h00, 32'sh80000000,
                                    mcvrd_pkg::RATE_LEN));
        directed.push_back(make_cmd(mcvrd_pkg::OP_SET_RATE, 3'd7, 8'h00, 32'sd1,
                                    mcvrd_pkg::RATE_LEN));
        directed.push_back(make_cmd(mcvrd_pkg::OP_SET_RATE, 3'd7, 8'h00, 32'sd0,
                                    mcvrd_pkg::RATE_LEN));
        directed.push_back(make_cmd(mcvrd_pkg::OP_SET_RATE, 3'd7, 8'h00, 32'sd1023,
                                    mcvrd_pkg::RATE_LEN));
        directed.push_back(make_cmd(mcvrd_pkg::OP_SET_RATE, 3'd7, 8'h00, 32'sd2048,
                                    mcvrd_pkg::RATE_LEN));
        directed.push_back(make_cmd(mcvrd_pkg::OP_SET_RATE, 3'd7, 8'h00, 32'sd2, 8'd3));
        directed.push_back(make_cmd(mcvrd_pkg::OP_SET_RATE, 3'd7, 8'h00, 32'sd2, 8'd255));
        // Rate raised mid-count: the count passes below zero and must still fire.
        directed.push_back(make_cmd(mcvrd_pkg::OP_SET_RATE, 3'd7, 8'h00, 32'sd512,
                                    mcvrd_pkg::RATE_LEN));
        directed.push_back(make_cmd(mcvrd_pkg::OP_TICK, 3'd0, 8'h80, 32'sd0, 8'd0));
        directed.push_back(make_cmd(mcvrd_pkg::OP_SET_RATE, 3'd7, 8'h00, 32'sd1024,
                                    mcvrd_pkg::RATE_LEN));
        directed.push_back(make_cmd(mcvrd_pkg::OP_TICK, 3'd0, 8'hFF, 32'sd0, 8'd0));
        directed.push_back(make_cmd(mcvrd_pkg::OP_ARM, 3'd0, 8'h00, 32'sd0, 8'd0));
        directed.push_back(make_cmd(mcvrd_pkg::OP_CLOSE, 3'd7, 8'h00, 32'sd0, 8'd0));
        directed.push_back(make_cmd(OP_SPARE_6, 3'd3, 8'hFF, 32'sd4, mcvrd_pkg::RATE_LEN));
        directed.push_back(make_cmd(OP_SPARE_7, 3'd5, 8'hFF, 32'sd4, mcvrd_pkg::RATE_LEN));
        directed.push_back(make_cmd(mcvrd_pkg::OP_TICK, 3'd0, 8'h00, 32'sd0, 8'd0));
        directed.push_back(make_cmd(mcvrd_pkg::OP_SET_RATE, 3'd3, 8'h00, 32'sd2,
                                    mcvrd_pkg::RATE_LEN));

        foreach (directed[k]) begin
            issue_cmd(directed[k]);
            pause(gap_len());
        end
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // Some stretches of back-to-back transactions with no gaps at all.
            if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
            if (i > 0 && i % 250 == 0) wait_drained();
            issue_cmd(random_cmd());
            if (!calm) pause(gap_len());
        end

        // Allow extra slack after the last response has come back.
        wait_drained();
        repeat (20) @(posedge i_clk);
        check_end <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("multi_channel_virtual_rate_divider: match");
        end else begin
            $display("multi_channel_virtual_rate_divider: mismatch");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #20000000;
        $display("multi_channel_virtual_rate_divider: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
design/mcvrd_pkg.sv
design/multi_channel_virtual_rate_divider.sv
tb/mcvrd_checker.sv
tb/tb_multi_channel_virtual_rate_divider.sv
